/* src/qrv_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_pkg: shared constants and types for the quaternion vector rotator
// Field widths, queue sizing, the queue status bundle and the width helper
// used by the coefficient and rotation stages.
// ---------------------------------------------------------------------------
package qrv_pkg;

   // quaternion components are fixed at 16 bits, Q2.14 by default
   localparam int QUAT_WIDTH         = 16;
   localparam int DATA_WIDTH_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   // coefficient queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qrv_fifo_status_type;

   // width of an unrounded matrix term: holds 1.0 at 2*frac fraction bits
   // and the sum of two doubled products, with headroom for rounding
   function automatic int raw_width(input int frac);
      int base;
      base = (2 * frac > 2 * QUAT_WIDTH) ? 2 * frac : 2 * QUAT_WIDTH;
      return base + 3;
   endfunction

endpackage

/* src/qrv_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_req_if: request channel of the quaternion vector rotator
// Carries one quaternion and one vector per request with valid/ready.
// ---------------------------------------------------------------------------
interface qrv_req_if #(
   parameter int DATA_WIDTH = qrv_pkg::DATA_WIDTH_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic signed [qrv_pkg::QUAT_WIDTH-1:0]  quat_x;
   logic signed [qrv_pkg::QUAT_WIDTH-1:0]  quat_y;
   logic signed [qrv_pkg::QUAT_WIDTH-1:0]  quat_z;
   logic signed [qrv_pkg::QUAT_WIDTH-1:0]  quat_w;
   logic signed [DATA_WIDTH-1:0]           vec_x;
   logic signed [DATA_WIDTH-1:0]           vec_y;
   logic signed [DATA_WIDTH-1:0]           vec_z;

   modport source (
      output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
      input  ready
   );
   modport sink (
      input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
      output ready
   );
endinterface

/* src/qrv_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_rsp_if: result channel of the quaternion vector rotator
// Carries the rotated vector and the clip flag with valid/ready.
// ---------------------------------------------------------------------------
interface qrv_rsp_if #(
   parameter int DATA_WIDTH = qrv_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] rot_x;
   logic signed [DATA_WIDTH-1:0] rot_y;
   logic signed [DATA_WIDTH-1:0] rot_z;
   logic                         clipped;

   modport source (
      output valid, rot_x, rot_y, rot_z, clipped,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, clipped,
      output ready
   );
endinterface

/* src/quaternion_rotate_vector.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_rotate_vector: rotate a 3-D vector by a quaternion
// Matrix build in a front pipe, queue, then multiply, round and saturate.
// ---------------------------------------------------------------------------
//
// Each request carries a quaternion (signed, COEF_FRAC_BITS fraction bits)
// and a signed integer vector; each response carries the rotated vector,
// rounded half up and saturated to DATA_WIDTH bits, with clipped set when any
// component was clamped to a rail. The quaternion is used as given, so a non-unit
// quaternion scales as well as rotates. Throughput is one request per clock,
// sustained while the response side takes one per clock; a request passes
// through two coefficient stages, the queue write, one multiply stage and one
// output register before its response is valid. The front admits a request
// by credit against the 4-entry coefficient queue, so a stalled response side
// backs up into the queue first and request ready drops only once the queue
// and the two front stages together hold four requests.
//
module quaternion_rotate_vector #(
   parameter int DATA_WIDTH     = qrv_pkg::DATA_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = qrv_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   qrv_req_if.sink      req_chan,
   qrv_rsp_if.source    rsp_chan
);
   import qrv_pkg::*;

   localparam int COEF_W  = raw_width(COEF_FRAC_BITS) - COEF_FRAC_BITS;
   // queue entry: nine coefficients plus the three vector components
   localparam int ENTRY_W = 9 * COEF_W + 3 * DATA_WIDTH;

   qrv_fifo_status_type q_status;
   logic                push_valid;
   logic [ENTRY_W-1:0]  push_data;
   logic                pop;
   logic [ENTRY_W-1:0]  head_data;
   logic                front_ready;

   // front: take requests and build the rotation matrix
   qrv_front #(
      .DATA_WIDTH     (DATA_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ENTRY_W        (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (front_ready),
      .req_quat_x (req_chan.quat_x),
      .req_quat_y (req_chan.quat_y),
      .req_quat_z (req_chan.quat_z),
      .req_quat_w (req_chan.quat_w),
      .req_vec_x  (req_chan.vec_x),
      .req_vec_y  (req_chan.vec_y),
      .req_vec_z  (req_chan.vec_z),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   assign req_chan.ready = front_ready;

   // queue: decouple matrix build from the response side
   qrv_fifo #(
      .ENTRY_W (ENTRY_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .status     (q_status)
   );

   // back: apply the matrix and hold the response until taken
   qrv_back #(
      .DATA_WIDTH     (DATA_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ENTRY_W        (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_rot_x   (rsp_chan.rot_x),
      .rsp_rot_y   (rsp_chan.rot_y),
      .rsp_rot_z   (rsp_chan.rot_z),
      .rsp_clipped (rsp_chan.clipped)
   );

endmodule

/* src/qrv_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_front: request intake and rotation-matrix build
// Two free-running stages: coordinate products, then the nine
// rounded coefficients. Admission is by credit against the queue.
// ---------------------------------------------------------------------------
module qrv_front #(
   parameter int DATA_WIDTH     = qrv_pkg::DATA_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = qrv_pkg::COEF_FRAC_BITS_DEF,
   parameter int ENTRY_W        = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] req_quat_z,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] req_quat_w,
   input  logic signed [DATA_WIDTH-1:0]          req_vec_x,
   input  logic signed [DATA_WIDTH-1:0]          req_vec_y,
   input  logic signed [DATA_WIDTH-1:0]          req_vec_z,
   input  qrv_pkg::qrv_fifo_status_type          q_status,
   output logic                                  push_valid,
   output logic [ENTRY_W-1:0]                    push_data
);
   import qrv_pkg::*;

   localparam int RAW_W  = raw_width(COEF_FRAC_BITS);
   localparam int COEF_W = RAW_W - COEF_FRAC_BITS;
   localparam int PROD_W = 2 * QUAT_WIDTH;

   localparam logic signed [RAW_W-1:0] ONE  = RAW_W'(1) << (2 * COEF_FRAC_BITS);
   localparam logic signed [RAW_W-1:0] HALF = RAW_W'(1) << (COEF_FRAC_BITS - 1);

   // product slots
   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_XZ = 4;
   localparam int P_YZ = 5;
   localparam int P_WX = 6;
   localparam int P_WY = 7;
   localparam int P_WZ = 8;

   logic                     f1_valid_ff, f1_valid_in;
   logic                     f2_valid_ff, f2_valid_in;
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [DATA_WIDTH-1:0] vec1_ff [3];
   logic signed [DATA_WIDTH-1:0] vec2_ff [3];
   logic signed [RAW_W-1:0]  dbl [9];
   logic signed [RAW_W-1:0]  raw [9];
   logic signed [RAW_W-1:0]  rnd [9];
   logic signed [COEF_W-1:0] coef_in [9];
   logic signed [COEF_W-1:0] coef_ff [9];
   logic [QCNT_W:0]          in_flight;

   // credit: queued entries plus the two stages may not exceed the queue
   always_comb begin
      in_flight = {1'b0, q_status.count} + (QCNT_W + 1)'(f1_valid_ff)
                  + (QCNT_W + 1)'(f2_valid_ff);
      req_ready = in_flight < (QCNT_W + 1)'(QUEUE_DEPTH);
   end

   always_comb begin
      f1_valid_in      = req_valid && req_ready;
      f2_valid_in      = f1_valid_ff;
      prod_in[P_XX]    = req_quat_x * req_quat_x;
      prod_in[P_YY]    = req_quat_y * req_quat_y;
      prod_in[P_ZZ]    = req_quat_z * req_quat_z;
      prod_in[P_XY]    = req_quat_x * req_quat_y;
      prod_in[P_XZ]    = req_quat_x * req_quat_z;
      prod_in[P_YZ]    = req_quat_y * req_quat_z;
      prod_in[P_WX]    = req_quat_w * req_quat_x;
      prod_in[P_WY]    = req_quat_w * req_quat_y;
      prod_in[P_WZ]    = req_quat_w * req_quat_z;
   end

   // build the matrix from the doubled products and round each term
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dbl[i] = RAW_W'(prod_ff[i]) <<< 1;
      end
      raw[0] = ONE - (dbl[P_YY] + dbl[P_ZZ]);
      raw[1] = dbl[P_XY] - dbl[P_WZ];
      raw[2] = dbl[P_XZ] + dbl[P_WY];
      raw[3] = dbl[P_XY] + dbl[P_WZ];
      raw[4] = ONE - (dbl[P_XX] + dbl[P_ZZ]);
      raw[5] = dbl[P_YZ] - dbl[P_WX];
      raw[6] = dbl[P_XZ] - dbl[P_WY];
      raw[7] = dbl[P_YZ] + dbl[P_WX];
      raw[8] = ONE - (dbl[P_XX] + dbl[P_YY]);
      for (int i = 0; i < 9; i++) begin
         rnd[i]     = (raw[i] + HALF) >>> COEF_FRAC_BITS;
         coef_in[i] = rnd[i][COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      vec1_ff[0] <= req_vec_x;
      vec1_ff[1] <= req_vec_y;
      vec1_ff[2] <= req_vec_z;
      coef_ff    <= coef_in;
      vec2_ff    <= vec1_ff;
   end

   // queue entry: vector in the low bits, coefficients above
   always_comb begin
      push_valid = f2_valid_ff;
      push_data  = '0;
      for (int k = 0; k < 3; k++) begin
         push_data[k*DATA_WIDTH +: DATA_WIDTH] = vec2_ff[k];
      end
      for (int j = 0; j < 9; j++) begin
         push_data[3*DATA_WIDTH + j*COEF_W +: COEF_W] = coef_ff[j];
      end
   end

endmodule

/* src/qrv_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_fifo: coefficient queue between front and back
// Small register queue; the head entry is visible without a pop.
// ---------------------------------------------------------------------------
module qrv_fifo #(
   parameter int ENTRY_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  logic [ENTRY_W-1:0]           push_data,
   input  logic                         pop,
   output logic [ENTRY_W-1:0]           head_data,
   output qrv_pkg::qrv_fifo_status_type status
);
   import qrv_pkg::*;

   logic [ENTRY_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.count = count_ff;

   // front credit must keep pushes off a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> count_ff < QCNT_W'(QUEUE_DEPTH))
      else $error("qrv_fifo: push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("qrv_fifo: pop from empty queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("qrv_fifo: pointers disagree with count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("qrv_fifo: count missed a push");

endmodule

/* src/qrv_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrv_back: matrix-vector multiply, rounding and saturation
// Stage one multiplies the nine coefficients by the vector; stage two sums
// each row, rounds, saturates and holds the result until taken.
// ---------------------------------------------------------------------------
module qrv_back #(
   parameter int DATA_WIDTH     = qrv_pkg::DATA_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = qrv_pkg::COEF_FRAC_BITS_DEF,
   parameter int ENTRY_W        = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qrv_pkg::qrv_fifo_status_type q_status,
   input  logic [ENTRY_W-1:0]           head_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_x,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_y,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_z,
   output logic                         rsp_clipped
);
   import qrv_pkg::*;

   localparam int COEF_W = raw_width(COEF_FRAC_BITS) - COEF_FRAC_BITS;
   localparam int MUL_W  = COEF_W + DATA_WIDTH;
   localparam int ACC_W  = MUL_W + 2;

   localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

   logic                         advance;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [COEF_W-1:0]     coef [9];
   logic signed [DATA_WIDTH-1:0] vec [3];
   logic signed [MUL_W-1:0]      mul_in [9];
   logic signed [MUL_W-1:0]      mul_ff [9];
   logic signed [ACC_W-1:0]      acc [3];
   logic signed [ACC_W-1:0]      rnd [3];
   logic signed [DATA_WIDTH-1:0] rot_in [3];
   logic signed [DATA_WIDTH-1:0] rot_ff [3];
   logic [2:0]                   clip;
   logic                         clip_ff;

   // whole back pipe moves when the output slot is free or being drained
   always_comb begin
      advance      = !out_valid_ff || rsp_ready;
      pop          = advance && !q_status.empty;
      s1_valid_in  = advance ? !q_status.empty : s1_valid_ff;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec[k] = head_data[k*DATA_WIDTH +: DATA_WIDTH];
      end
      for (int j = 0; j < 9; j++) begin
         coef[j] = head_data[3*DATA_WIDTH + j*COEF_W +: COEF_W];
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            mul_in[3*r + k] = coef[3*r + k] * vec[k];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'(mul_ff[3*r]) + ACC_W'(mul_ff[3*r + 1])
                  + ACC_W'(mul_ff[3*r + 2]);
         rnd[r] = (acc[r] + HALF) >>> COEF_FRAC_BITS;
         if (rnd[r] > S_MAX) begin
            rot_in[r] = S_MAX[DATA_WIDTH-1:0];
            clip[r]   = 1'b1;
         end else if (rnd[r] < S_MIN) begin
            rot_in[r] = S_MIN[DATA_WIDTH-1:0];
            clip[r]   = 1'b1;
         end else begin
            rot_in[r] = rnd[r][DATA_WIDTH-1:0];
            clip[r]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff  <= mul_in;
         rot_ff  <= rot_in;
         clip_ff <= |clip;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_rot_x   = rot_ff[0];
   assign rsp_rot_y   = rot_ff[1];
   assign rsp_rot_z   = rot_ff[2];
   assign rsp_clipped = clip_ff;

endmodule
